FILE: hdl/gcd_pkg.sv
// Shared types, constants and helper functions for the great-circle distance pipeline.
// No dependencies; every other file in this folder imports it.
`timescale 1ns / 1ps

package gcd_pkg;

    localparam int CW           = 34;
    localparam int ITER_DEFAULT = 24;
    localparam int ITER_MAX     = 32;
    localparam int SQRT_STEPS   = 32;
    localparam int LANES        = 4;

    localparam int RADIUS_W     = 23;
    localparam int DIST_W       = 25;
    localparam int MAG_W        = 24;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

    localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;

    localparam logic signed [26:0] DEG90_Q17  = 27'sd11796480;
    localparam logic signed [26:0] DEG180_Q17 = 27'sd23592960;

    // pi * 2^32 = RAD_A * (45 * 2^21) + RAD_B
    localparam logic [7:0]  RAD_A   = 8'd142;
    localparam logic [26:0] RAD_B   = 27'd92236425;
    localparam logic [50:0] RAD_RND = 51'd47185920;
    // ceil(2^41 / 45)
    localparam logic [35:0] RECIP_M = 36'd48867183457;

    localparam logic [DIST_W:0] DIST_MAX = 26'd33554431;

    typedef logic signed [CW-1:0] cw_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        neg;
        cw_t [LANES-1:0]   x;
        cw_t [LANES-1:0]   y;
        cw_t [LANES-1:0]   z;
    } rot_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] na;
        logic [63:0] nb;
        logic [63:0] ra;
        logic [63:0] rb;
    } sq_t;

    typedef struct packed {
        logic valid;
        cw_t  x;
        cw_t  y;
        cw_t  z;
    } vec_t;

    function automatic cw_t atan_q30(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h00080000;
            12: v = 32'h00040000;
            13: v = 32'h00020000;
            14: v = 32'h00010000;
            15: v = 32'h00008000;
            16: v = 32'h00004000;
            17: v = 32'h00002000;
            18: v = 32'h00001000;
            19: v = 32'h00000800;
            20: v = 32'h00000400;
            21: v = 32'h00000200;
            22: v = 32'h00000100;
            23: v = 32'h00000080;
            24: v = 32'h00000040;
            25: v = 32'h00000020;
            26: v = 32'h00000010;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return cw_t'({2'b00, v});
    endfunction

    // Q30 product, rounded half up
    function automatic cw_t mul_q30(input cw_t a, input cw_t b);
        logic signed [2*CW-1:0] p;
        p = (2*CW)'(a) * (2*CW)'(b) + (2*CW)'(64'sd536870912);
        p = p >>> 30;
        return p[CW-1:0];
    endfunction

endpackage

FILE: hdl/gcd_rot_cell.sv
// One CORDIC rotation step applied to the four angle lanes.
// Depends on gcd_pkg for the lane word and the arctangent table.
`timescale 1ns / 1ps

module gcd_rot_cell #(
    parameter int STEP = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  gcd_pkg::rot_t din,
    output gcd_pkg::rot_t dout
);
    import gcd_pkg::*;

    localparam cw_t ANG = atan_q30(STEP);

    rot_t cell_reg;
    rot_t cell_next;

    always_comb
    begin
        cw_t tx;
        cw_t ty;
        cell_next = din;
        for (int k = 0; k < LANES; k++)
        begin
            tx = $signed(din.x[k]) >>> STEP;
            ty = $signed(din.y[k]) >>> STEP;
            if ($signed(din.z[k]) >= 0)
            begin
                cell_next.x[k] = din.x[k] - ty;
                cell_next.y[k] = din.y[k] + tx;
                cell_next.z[k] = din.z[k] - ANG;
            end
            else
            begin
                cell_next.x[k] = din.x[k] + ty;
                cell_next.y[k] = din.y[k] - tx;
                cell_next.z[k] = din.z[k] + ANG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.valid <= 1'b0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

FILE: hdl/gcd_sqrt_cell.sv
// One digit step of two integer square roots, a and 1 - a, side by side.
// Depends on gcd_pkg for the root word.
`timescale 1ns / 1ps

module gcd_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic         clk,
    input  logic         rst_n,
    input  gcd_pkg::sq_t din,
    output gcd_pkg::sq_t dout
);
    import gcd_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (62 - 2*STEP);

    sq_t cell_reg;
    sq_t cell_next;

    always_comb
    begin
        logic [63:0] sa;
        logic [63:0] sb;
        cell_next = din;
        sa = din.ra + BIT;
        sb = din.rb + BIT;
        if (din.na >= sa)
        begin
            cell_next.na = din.na - sa;
            cell_next.ra = (din.ra >> 1) + BIT;
        end
        else
        begin
            cell_next.ra = din.ra >> 1;
        end
        if (din.nb >= sb)
        begin
            cell_next.nb = din.nb - sb;
            cell_next.rb = (din.rb >> 1) + BIT;
        end
        else
        begin
            cell_next.rb = din.rb >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.valid <= 1'b0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

FILE: hdl/gcd_vec_cell.sv
// One CORDIC vectoring step that accumulates the central angle.
// Depends on gcd_pkg for the word type and the arctangent table.
`timescale 1ns / 1ps

module gcd_vec_cell #(
    parameter int STEP = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  gcd_pkg::vec_t din,
    output gcd_pkg::vec_t dout
);
    import gcd_pkg::*;

    localparam cw_t ANG = atan_q30(STEP);

    vec_t cell_reg;
    vec_t cell_next;

    always_comb
    begin
        cw_t tx;
        cw_t ty;
        cell_next = din;
        tx = $signed(din.x) >>> STEP;
        ty = $signed(din.y) >>> STEP;
        if ($signed(din.y) >= 0)
        begin
            cell_next.x = din.x + ty;
            cell_next.y = din.y - tx;
            cell_next.z = din.z + ANG;
        end
        else
        begin
            cell_next.x = din.x - ty;
            cell_next.y = din.y + tx;
            cell_next.z = din.z - ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.valid <= 1'b0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

FILE: hdl/great_circle_distance.sv
// Top level of the haversine distance pipeline: front end, cell chains, back end, APB register.
// Depends on gcd_pkg, gcd_rot_cell, gcd_sqrt_cell and gcd_vec_cell.
`timescale 1ns / 1ps

// Fully pipelined: one coordinate pair is taken on every cycle that start is high (busy is
// always low), and each distance comes out on done after it has passed through the two CORDIC
// cell chains of ANGLE_ITERATIONS cells each (iterations counted up to 32), the 32-cell
// square-root chain, and nine stages of angle conversion and multiplication. The receiver
// cannot stall; done is a single cycle strobe. The sphere radius register sits at byte
// address 0.

module great_circle_distance #(
    parameter int ANGLE_ITERATIONS = gcd_pkg::ITER_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  logic signed [23:0]  first_latitude,
    input  logic signed [24:0]  first_longitude,
    input  logic signed [23:0]  second_latitude,
    input  logic signed [24:0]  second_longitude,
    output logic                done,
    output logic [24:0]         distance_m
);
    import gcd_pkg::*;

    localparam int NCELL = (ANGLE_ITERATIONS < ITER_MAX) ? ANGLE_ITERATIONS : ITER_MAX;

    logic [RADIUS_W-1:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (psel && penable && pwrite && pready && !paddr[2])
        begin
            radius_reg <= pwdata[RADIUS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-RADIUS_W){1'b0}}, radius_reg};
    assign busy   = 1'b0;

    // front end: reduce angles and take magnitudes
    logic signed [26:0] ch_d [LANES];
    logic [MAG_W-1:0]   mag_next [LANES];
    logic [LANES-1:0]   sgn_next;
    logic [1:0]         neg_next;

    always_comb
    begin
        logic signed [26:0] r;
        ch_d[0] = 27'(second_latitude) - 27'(first_latitude);
        ch_d[1] = 27'(second_longitude) - 27'(first_longitude);
        ch_d[2] = 27'(first_latitude) <<< 1;
        ch_d[3] = 27'(second_latitude) <<< 1;
        neg_next = '0;
        sgn_next = '0;
        for (int k = 0; k < 2; k++)
        begin
            if (ch_d[k] >= DEG90_Q17)
            begin
                r = ch_d[k] - DEG180_Q17;
            end
            else if (ch_d[k] < -DEG90_Q17)
            begin
                r = ch_d[k] + DEG180_Q17;
            end
            else
            begin
                r = ch_d[k];
            end
            sgn_next[k] = r[26];
            r = r[26] ? -r : r;
            mag_next[k] = r[MAG_W-1:0];
        end
        for (int k = 2; k < LANES; k++)
        begin
            r = ch_d[k][26] ? -ch_d[k] : ch_d[k];
            if (r > DEG90_Q17)
            begin
                r = DEG180_Q17 - r;
                neg_next[k-2] = 1'b1;
            end
            mag_next[k] = r[MAG_W-1:0];
        end
    end

    logic             v1_reg, v2_reg, v3_reg;
    logic [MAG_W-1:0] mag_reg [LANES];
    logic [LANES-1:0] sgn1_reg, sgn2_reg, sgn3_reg;
    logic [1:0]       neg1_reg, neg2_reg, neg3_reg;
    logic [50:0]      p_reg [LANES];
    logic [31:0]      m142_reg [LANES];
    logic [31:0]      m142b_reg [LANES];
    logic [47:0]      mlo_reg [LANES];
    logic [47:0]      mhi_reg [LANES];
    rot_t             rot_bus [NCELL+1];
    rot_t             rot_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            rot_bus[0].valid <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            rot_bus[0] <= rot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [29:0] t;
        sgn1_reg <= sgn_next;
        neg1_reg <= neg_next;
        sgn2_reg <= sgn1_reg;
        neg2_reg <= neg1_reg;
        sgn3_reg <= sgn2_reg;
        neg3_reg <= neg2_reg;
        for (int k = 0; k < LANES; k++)
        begin
            mag_reg[k]   <= mag_next[k];
            p_reg[k]     <= 51'(mag_reg[k]) * 51'(RAD_B);
            m142_reg[k]  <= 32'(mag_reg[k]) * 32'(RAD_A);
            m142b_reg[k] <= m142_reg[k];
            t             = 30'((p_reg[k] + RAD_RND) >> 21);
            mlo_reg[k]   <= 48'(t) * 48'(RECIP_M[17:0]);
            mhi_reg[k]   <= 48'(t) * 48'(RECIP_M[35:18]);
        end
    end

    always_comb
    begin
        logic [66:0] s;
        logic [32:0] r;
        rot_next.valid = v3_reg;
        rot_next.neg   = neg3_reg;
        for (int k = 0; k < LANES; k++)
        begin
            s = {1'b0, mhi_reg[k], 18'd0} + 67'(mlo_reg[k]);
            r = 33'(m142b_reg[k]) + 33'(s[66:41]);
            rot_next.x[k] = INV_GAIN;
            rot_next.y[k] = '0;
            rot_next.z[k] = sgn3_reg[k] ? -cw_t'(r) : cw_t'(r);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_rot
            gcd_rot_cell #(.STEP(gi)) u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .din  (rot_bus[gi]),
                .dout (rot_bus[gi+1])
            );
        end
    endgenerate

    // back end: haversine term a and 1 - a
    logic e1_v_reg, e2_v_reg;
    cw_t  sqlat1_reg, sqlon_reg, cc_reg, sqlat2_reg, t2_reg;
    sq_t  sq_bus [SQRT_STEPS+1];
    sq_t  sq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v_reg <= 1'b0;
            e2_v_reg <= 1'b0;
            sq_bus[0].valid <= 1'b0;
        end
        else
        begin
            e1_v_reg  <= rot_bus[NCELL].valid;
            e2_v_reg  <= e1_v_reg;
            sq_bus[0] <= sq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cw_t c1;
        cw_t c2;
        c1 = rot_bus[NCELL].neg[0] ? -rot_bus[NCELL].x[2] : rot_bus[NCELL].x[2];
        c2 = rot_bus[NCELL].neg[1] ? -rot_bus[NCELL].x[3] : rot_bus[NCELL].x[3];
        sqlat1_reg <= mul_q30(rot_bus[NCELL].y[0], rot_bus[NCELL].y[0]);
        sqlon_reg  <= mul_q30(rot_bus[NCELL].y[1], rot_bus[NCELL].y[1]);
        cc_reg     <= mul_q30(c1, c2);
        sqlat2_reg <= sqlat1_reg;
        t2_reg     <= mul_q30(cc_reg, sqlon_reg);
    end

    always_comb
    begin
        cw_t a;
        cw_t b;
        a = sqlat2_reg + t2_reg;
        b = ONE_Q30 - a;
        if (a < 0)
        begin
            a = '0;
        end
        if (b < 0)
        begin
            b = '0;
        end
        sq_next.valid = e2_v_reg;
        sq_next.na    = 64'(unsigned'(a)) << 30;
        sq_next.nb    = 64'(unsigned'(b)) << 30;
        sq_next.ra    = '0;
        sq_next.rb    = '0;
    end

    generate
        for (gi = 0; gi < SQRT_STEPS; gi++)
        begin : g_sqrt
            gcd_sqrt_cell #(.STEP(gi)) u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .din  (sq_bus[gi]),
                .dout (sq_bus[gi+1])
            );
        end
    endgenerate

    vec_t vec_bus [NCELL+1];

    assign vec_bus[0].valid = sq_bus[SQRT_STEPS].valid;
    assign vec_bus[0].x     = cw_t'(sq_bus[SQRT_STEPS].rb[CW-1:0]);
    assign vec_bus[0].y     = cw_t'(sq_bus[SQRT_STEPS].ra[CW-1:0]);
    assign vec_bus[0].z     = '0;

    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_vec
            gcd_vec_cell #(.STEP(gi)) u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .din  (vec_bus[gi]),
                .dout (vec_bus[gi+1])
            );
        end
    endgenerate

    // scale by radius, round and clamp
    logic        e5_v_reg;
    logic [53:0] prod_reg;
    logic        done_reg;
    logic [24:0] dist_reg;
    logic [30:0] theta;
    logic [54:0] dsum;

    assign theta = ($signed(vec_bus[NCELL].z) < 0) ? '0 : vec_bus[NCELL].z[30:0];
    assign dsum  = 55'(prod_reg) + 55'(64'd268435456);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e5_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            e5_v_reg <= vec_bus[NCELL].valid;
            done_reg <= e5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 54'(radius_reg) * 54'(theta);
        if (dsum[54:29] > DIST_MAX)
        begin
            dist_reg <= DIST_MAX[DIST_W-1:0];
        end
        else
        begin
            dist_reg <= dsum[53:29];
        end
    end

    assign done       = done_reg;
    assign distance_m = dist_reg;

endmodule

FILE: bench/great_circle_distance_checker.sv
// Checker for the great-circle distance block: tracks the radius register, predicts each distance.
// Depends on gcd_pkg; instantiated by great_circle_distance_tb beside the block.
`timescale 1ns / 1ps

module great_circle_distance_checker #(
    parameter int ANGLE_ITERATIONS = gcd_pkg::ITER_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                start,
    input  logic                busy,
    input  logic signed [23:0]  first_latitude,
    input  logic signed [24:0]  first_longitude,
    input  logic signed [23:0]  second_latitude,
    input  logic signed [24:0]  second_longitude,
    input  logic                done,
    input  logic [24:0]         distance_m,
    output int                  failures,
    output int                  pending,
    output int                  words_in,
    output int                  words_out
);
    import gcd_pkg::*;

    localparam longint PI_Q32     = 64'sd13493037705;
    localparam longint INV_GAIN_L = 64'sd652032874;
    localparam longint ONE_L      = 64'sd1073741824;
    localparam longint D90        = 64'sd11796480;
    localparam longint D180       = 64'sd23592960;
    localparam longint D360       = 64'sd47185920;
    localparam longint RAD_DIV    = 64'sd94371840;
    localparam longint DMAX       = 64'sd33554431;
    localparam logic   REG_RADIUS = 1'b0;

    logic [RADIUS_W-1:0] radius;
    logic [DIST_W-1:0]   expected_dist[$];
    int                  mismatches;

    function automatic longint arctan_entry(input int i);
        longint t[32];
        t = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
              64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
              64'h000FFFFF, 64'h00080000, 64'h00040000, 64'h00020000, 64'h00010000,
              64'h00008000, 64'h00004000, 64'h00002000, 64'h00001000, 64'h00000800,
              64'h00000400, 64'h00000200, 64'h00000100, 64'h00000080, 64'h00000040,
              64'h00000020, 64'h00000010, 64'h00000008, 64'h00000004, 64'h00000002,
              64'h00000001, 64'h00000000};
        return t[i];
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint to_radians(input longint d);
        longint mag;
        longint r;
        mag = d < 0 ? -d : d;
        r = (mag * PI_Q32 + RAD_DIV / 2) / RAD_DIV;
        return d < 0 ? -r : r;
    endfunction

    function automatic longint wrap_angle(input longint d, input longint period);
        longint r;
        r = d % period;
        if (r < 0) r += period;
        if (r >= period / 2) r -= period;
        return r;
    endfunction

    function automatic void cordic_rotate(input longint z, output longint c, output longint s);
        longint x;
        longint y;
        longint tx;
        longint ty;
        x = INV_GAIN_L;
        y = 0;
        for (int i = 0; i < ANGLE_ITERATIONS && i < 32; i++)
        begin
            ty = y >>> i;
            tx = x >>> i;
            if (z >= 0)
            begin
                x -= ty; y += tx; z -= arctan_entry(i);
            end
            else
            begin
                x += ty; y -= tx; z += arctan_entry(i);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint cordic_angle(input longint x, input longint y);
        longint z;
        longint tx;
        longint ty;
        z = 0;
        for (int i = 0; i < ANGLE_ITERATIONS && i < 32; i++)
        begin
            ty = y >>> i;
            tx = x >>> i;
            if (y >= 0)
            begin
                x += ty; y -= tx; z += arctan_entry(i);
            end
            else
            begin
                x -= ty; y += tx; z -= arctan_entry(i);
            end
        end
        return z;
    endfunction

    function automatic longint int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint half_sine_squared(input longint diff_q17);
        longint c;
        longint s;
        cordic_rotate(to_radians(wrap_angle(diff_q17, D180)), c, s);
        return qmul(s, s);
    endfunction

    function automatic longint latitude_cosine(input longint lat_q16);
        longint r;
        longint mag;
        longint c;
        longint s;
        bit     flip;
        r = wrap_angle(lat_q16 * 2, D360);
        mag = r < 0 ? -r : r;
        flip = 0;
        if (mag > D90)
        begin
            mag = D180 - mag;
            flip = 1;
        end
        cordic_rotate(to_radians(mag), c, s);
        return flip ? -c : c;
    endfunction

    function automatic logic [DIST_W-1:0] haversine_distance(
        input longint lat1, input longint lon1, input longint lat2, input longint lon2,
        input longint r_m);
        longint a;
        longint b;
        longint theta;
        longint d;
        a = half_sine_squared(lat2 - lat1)
          + qmul(qmul(latitude_cosine(lat1), latitude_cosine(lat2)),
                 half_sine_squared(lon2 - lon1));
        b = ONE_L - a;
        if (a < 0) a = 0;
        if (b < 0) b = 0;
        theta = cordic_angle(int_sqrt(longint'(b) <<< 30), int_sqrt(longint'(a) <<< 30));
        if (theta < 0) theta = 0;
        d = (r_m * theta + (64'sd1 <<< 28)) >>> 29;
        if (d > DMAX) d = DMAX;
        return d[DIST_W-1:0];
    endfunction

    assign pending = expected_dist.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius <= RADIUS_RESET;
            failures = 0;
            mismatches = 0;
            words_in = 0;
            words_out = 0;
            expected_dist.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_RADIUS)
                radius <= pwdata[RADIUS_W-1:0];
            if (start && !busy)
            begin
                expected_dist.insert(expected_dist.size(), haversine_distance(
                    first_latitude, first_longitude, second_latitude, second_longitude,
                    longint'(radius)));
                words_in++;
            end
            if (done)
            begin
                words_out++;
                if (expected_dist.size() == 0)
                begin
                    failures++;
                    if (mismatches++ < 10)
                        $display("unexpected distance word %0d", distance_m);
                end
                else
                begin
                    logic [DIST_W-1:0] want;
                    want = expected_dist.pop_front();
                    if (want !== distance_m)
                    begin
                        failures++;
                        if (mismatches++ < 10)
                            $display("distance mismatch: expected %0d, got %0d",
                                     want, distance_m);
                    end
                end
            end
        end
    end

endmodule

FILE: bench/great_circle_distance_tb.sv
// Top of the great-circle distance testbench: clock, reset, register writes and coordinate stimulus.
// Depends on gcd_pkg, great_circle_distance and great_circle_distance_checker.
`timescale 1ns / 1ps

module great_circle_distance_tb;
    import gcd_pkg::*;

    localparam int LATENCY = 41 + 2 * ITER_DEFAULT;
    localparam logic [2:0] ADDR_RADIUS = 3'd0;
    localparam int LAT_MAX = 5898240;
    localparam int LON_MAX = 11796480;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               psel = 0;
    logic               penable = 0;
    logic               pwrite = 0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               start = 0;
    logic               busy;
    logic signed [23:0] first_latitude = '0;
    logic signed [24:0] first_longitude = '0;
    logic signed [23:0] second_latitude = '0;
    logic signed [24:0] second_longitude = '0;
    logic               done;
    logic [24:0]        distance_m;
    int                 failures;
    int                 pending;
    int                 words_in;
    int                 words_out;
    int                 idle_pct;

    always #5 clk = ~clk;

    great_circle_distance dut (.*);

    great_circle_distance_checker u_checker (.*);

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    task automatic write_radius(input logic [31:0] value);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_RADIUS; pwdata <= value;
        @(posedge clk);
        penable <= 1;
        do @(negedge clk); while (!pready);
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic send_pair(input logic [23:0] lat1, input logic [24:0] lon1,
                             input logic [23:0] lat2, input logic [24:0] lon2);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        start <= 1;
        first_latitude <= lat1; first_longitude <= lon1;
        second_latitude <= lat2; second_longitude <= lon2;
        do @(negedge clk); while (busy);
        @(posedge clk);
    endtask

    task automatic send_point(input int lat1, input int lon1, input int lat2, input int lon2);
        send_pair(24'(lat1), 25'(lon1), 24'(lat2), 25'(lon2));
    endtask

    function automatic logic [23:0] pick_lat(input int mode);
        if (mode == 0) return 24'($urandom());
        return 24'($signed($urandom_range(2 * LAT_MAX)) - LAT_MAX);
    endfunction

    function automatic logic [24:0] pick_lon(input int mode);
        if (mode == 0) return 25'($urandom());
        return 25'($signed($urandom_range(2 * LON_MAX)) - LON_MAX);
    endfunction

    task automatic random_pairs(input int count);
        int mode;
        logic [23:0] la;
        logic [24:0] lo;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(9);
            la = pick_lat(1);
            lo = pick_lon(1);
            case (mode)
                0, 1: send_pair(pick_lat(0), pick_lon(0), pick_lat(0), pick_lon(0));
                2: send_pair(la, lo, -la, lo + 25'(LON_MAX));
                3: send_pair(la, lo, la + 24'($urandom_range(200)), lo - 25'($urandom_range(200)));
                default: send_pair(la, lo, pick_lat(1), pick_lon(1));
            endcase
        end
        start <= 0;
    endtask

    initial
    begin
        logic [31:0] radii[5];
        int          idles[5];
        radii = '{32'd1, 32'd8388607, 32'd0, 32'd1000000, 32'd6371000};
        idles = '{0, 50, 0, 12, 50};
        idle_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_point(0, 0, 0, 0);
        send_point(LAT_MAX, 0, -LAT_MAX, 0);
        send_point(0, 0, 0, LON_MAX);
        send_point(0, -LON_MAX, 0, LON_MAX);
        send_point(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        send_point(-LAT_MAX, 0, -LAT_MAX, 1);
        send_point(24'h7FFFFF, 25'h0FFFFFF, 24'h800000, 25'h1000000);
        send_point(24'h800000, 25'h1000000, 24'h7FFFFF, 25'h0FFFFFF);
        send_point(24'hFFFFFF, 25'h1FFFFFF, 24'h000001, 25'h0000001);
        send_point(24'h7FFFFF, 0, 24'h7FFFFF, LON_MAX);
        send_point(24'h800000, 0, 24'h7FFFFF, 0);
        send_point(3407872, 65536, -3407872, -LON_MAX + 65536);
        send_point(1, 0, 0, 1);
        send_point(LAT_MAX / 2, LON_MAX / 3, -LAT_MAX / 2, -LON_MAX / 3 * 2);
        send_point(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        start <= 0;
        drain();

        for (int p = 0; p < 5; p++)
        begin
            write_radius(radii[p]);
            idle_pct = idles[p];
            random_pairs(p == 2 ? 150 : 200);
            drain();
        end

        $display("%0d coordinate pairs sent over six radius settings, %0d distances checked",
                 words_in, words_out);
        if (failures == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
